// ===== rtl/ppmd_pkg.sv =====
// Package for the PPM frame decoder: beat payload types, configuration indexes,
// reset values, widths and the window bound bundle. No dependencies.
package ppmd_pkg;

    localparam int TIME_BITS = 16;
    localparam int CNT_W     = 5;
    localparam int MATCH_W   = 4;
    localparam int BOUND_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CNT_W-1:0]   MAX_SLOTS   = CNT_W'(16);
    localparam logic [MATCH_W-1:0] LOCK_FRAMES = MATCH_W'(10);

    localparam logic [CNT_W-1:0]     RST_MIN_CNT   = CNT_W'(4);
    localparam logic [CNT_W-1:0]     RST_MAX_CNT   = CNT_W'(8);
    localparam logic [TIME_BITS-1:0] RST_PREPULSE  = TIME_BITS'(300);
    localparam logic [TIME_BITS-1:0] RST_PULSE_MIN = TIME_BITS'(900);
    localparam logic [TIME_BITS-1:0] RST_PULSE_MAX = TIME_BITS'(2100);
    localparam logic [TIME_BITS-1:0] RST_FRAME     = TIME_BITS'(22500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CNT   = 3'd0,
        CFG_MAX_CNT   = 3'd1,
        CFG_PREPULSE  = 3'd2,
        CFG_PULSE_MIN = 3'd3,
        CFG_PULSE_MAX = 3'd4,
        CFG_FRAME     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 pin_edge;
        logic                 pin_level;
        logic [TIME_BITS-1:0] timestamp;
    } t_ppm_in;

    typedef struct packed {
        logic [CNT_W-1:0]     channel_index;
        logic [TIME_BITS-1:0] measured_width;
        logic                 width_valid;
        logic                 in_sync;
        logic                 sync_fault;
        logic                 channel_fault;
        logic                 count_locked;
        logic [CNT_W-1:0]     detected_channels;
    } t_ppm_out;

    typedef struct packed {
        logic signed [BOUND_W-1:0] chan_lo;
        logic signed [BOUND_W-1:0] chan_hi;
        logic signed [BOUND_W-1:0] sync_lo;
        logic signed [BOUND_W-1:0] sync_hi;
    } t_ppmd_bounds;

endpackage

// ===== rtl/ppmd_bounds.sv =====
// Window bound registers for the PPM frame decoder.
// Derives the channel and sync width windows from the configuration; uses ppmd_pkg.
module ppmd_bounds
    import ppmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic [CNT_W-1:0]     i_min_cnt,
    input  logic [CNT_W-1:0]     i_max_cnt,
    input  logic [TIME_BITS-1:0] i_prepulse,
    input  logic [TIME_BITS-1:0] i_pulse_min,
    input  logic [TIME_BITS-1:0] i_pulse_max,
    input  logic [TIME_BITS-1:0] i_frame,
    output t_ppmd_bounds         o_bounds
);

    localparam int PROD_W = CNT_W + TIME_BITS;

    t_ppmd_bounds              r_bounds;
    t_ppmd_bounds              n_bounds;
    logic [PROD_W-1:0]         max_prod;
    logic [PROD_W-1:0]         min_prod;
    logic signed [BOUND_W-1:0] frame_s;
    logic signed [BOUND_W-1:0] pre_s;

    always_comb begin
        max_prod = PROD_W'(i_max_cnt) * PROD_W'(i_pulse_max);
        min_prod = PROD_W'(i_min_cnt) * PROD_W'(i_pulse_min);
        frame_s  = signed'(BOUND_W'(i_frame));
        pre_s    = signed'(BOUND_W'(i_prepulse));
        n_bounds.chan_lo = signed'(BOUND_W'(i_pulse_min)) - pre_s;
        n_bounds.chan_hi = signed'(BOUND_W'(i_pulse_max)) - pre_s;
        n_bounds.sync_lo = frame_s - signed'(BOUND_W'(max_prod)) - pre_s;
        n_bounds.sync_hi = frame_s - signed'(BOUND_W'(min_prod)) - pre_s;
    end

    always_ff @(posedge i_clk) begin
        r_bounds <= n_bounds;
    end

    assign o_bounds = r_bounds;

endmodule

// ===== rtl/ppm_frame_decoder.sv =====
// A beat accepted into the input register is loaded into the result register once
// that register is free, and its result beat is offered to the output from there.
// Throughput: one beat per cycle; the input register moves on whenever the
// result register is empty or its beat is taken in the same cycle.
// Reset (i_rst_n low, synchronous) restores the configuration defaults,
// clears both stages and the slot state, and sets both fault flags.
// Top level of the PPM frame decoder; uses ppmd_pkg and ppmd_bounds.
module ppm_frame_decoder
    import ppmd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_ppm_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_ppm_out             o_out_data
);

    logic [CNT_W-1:0]     r_min_cnt;
    logic [CNT_W-1:0]     r_max_cnt;
    logic [TIME_BITS-1:0] r_prepulse;
    logic [TIME_BITS-1:0] r_pulse_min;
    logic [TIME_BITS-1:0] r_pulse_max;
    logic [TIME_BITS-1:0] r_frame;
    t_ppmd_bounds         bounds;

    logic                 r_in_valid;
    t_ppm_in              r_in;
    logic                 r_out_valid;
    t_ppm_out             r_out;

    logic [CNT_W-1:0]     r_slot;
    logic [TIME_BITS-1:0] r_start;
    logic                 r_sync;
    logic                 r_sync_err;
    logic                 r_chan_err;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_prev;
    logic [MATCH_W-1:0]   r_match;
    logic                 r_done;

    logic [CNT_W-1:0]     n_slot;
    logic [TIME_BITS-1:0] n_start;
    logic                 n_sync;
    logic                 n_sync_err;
    logic                 n_chan_err;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_prev;
    logic [MATCH_W-1:0]   n_match;
    logic                 n_done;
    t_ppm_out             n_out;

    logic                 out_free;
    logic                 fire;
    logic [TIME_BITS-1:0] width;
    logic signed [BOUND_W-1:0] width_s;
    logic                 chan_ok;
    logic                 sync_ok;
    logic                 count_ready;
    logic                 wvalid;

    ppmd_bounds u_bounds (
        .i_clk       (i_clk),
        .i_min_cnt   (r_min_cnt),
        .i_max_cnt   (r_max_cnt),
        .i_prepulse  (r_prepulse),
        .i_pulse_min (r_pulse_min),
        .i_pulse_max (r_pulse_max),
        .i_frame     (r_frame),
        .o_bounds    (bounds)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        width   = r_in.timestamp - r_start;
        width_s = signed'(BOUND_W'(width));
        chan_ok = (width_s >= bounds.chan_lo) && (width_s <= bounds.chan_hi);
        sync_ok = (width_s > bounds.sync_lo) && (width_s < bounds.sync_hi);

        n_slot      = r_slot;
        n_start     = r_start;
        n_sync      = r_sync;
        n_sync_err  = r_sync_err;
        n_chan_err  = r_chan_err;
        n_count     = r_count;
        n_prev      = r_prev;
        n_match     = r_match;
        n_done      = r_done;
        count_ready = 1'b0;
        wvalid      = 1'b0;

        if (r_in.pin_edge) begin
            if (r_in.pin_level) begin
                if (r_slot >= r_count || r_slot >= MAX_SLOTS) begin
                    n_sync = 1'b0;
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + CNT_W'(1);
                end
                n_start = r_in.timestamp;
            end else begin
                wvalid = 1'b1;
                if (r_sync) begin
                    if (chan_ok) begin
                        n_chan_err = 1'b0;
                    end else if (sync_ok) begin
                        if (!r_done) begin
                            n_count     = r_slot;
                            count_ready = 1'b1;
                            n_sync_err  = 1'b0;
                            n_sync      = 1'b1;
                        end else begin
                            n_sync_err = 1'b1;
                            n_sync     = 1'b0;
                        end
                        n_slot = '0;
                    end else begin
                        n_chan_err = 1'b1;
                    end
                end else begin
                    n_sync_err = !sync_ok;
                    n_sync     = sync_ok;
                    n_slot     = '0;
                end
            end
        end

        if (!r_done && count_ready) begin
            if (r_match < LOCK_FRAMES) begin
                n_match = (n_count == r_prev) ? r_match + MATCH_W'(1) : '0;
                n_prev  = n_count;
            end else begin
                n_done = 1'b1;
            end
        end

        n_out.channel_index     = n_slot;
        n_out.measured_width    = wvalid ? width : '0;
        n_out.width_valid       = wvalid;
        n_out.in_sync           = n_sync;
        n_out.sync_fault        = n_sync_err;
        n_out.channel_fault     = n_chan_err;
        n_out.count_locked      = n_done;
        n_out.detected_channels = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cnt   <= RST_MIN_CNT;
            r_max_cnt   <= RST_MAX_CNT;
            r_prepulse  <= RST_PREPULSE;
            r_pulse_min <= RST_PULSE_MIN;
            r_pulse_max <= RST_PULSE_MAX;
            r_frame     <= RST_FRAME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_CNT:   r_min_cnt   <= i_cfg_data[CNT_W-1:0];
                CFG_MAX_CNT:   r_max_cnt   <= i_cfg_data[CNT_W-1:0];
                CFG_PREPULSE:  r_prepulse  <= i_cfg_data[TIME_BITS-1:0];
                CFG_PULSE_MIN: r_pulse_min <= i_cfg_data[TIME_BITS-1:0];
                CFG_PULSE_MAX: r_pulse_max <= i_cfg_data[TIME_BITS-1:0];
                CFG_FRAME:     r_frame     <= i_cfg_data[TIME_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_start    <= '0;
            r_sync     <= 1'b0;
            r_sync_err <= 1'b1;
            r_chan_err <= 1'b1;
            r_count    <= RST_MAX_CNT;
            r_prev     <= '0;
            r_match    <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_MAX_CNT) begin
                r_count <= i_cfg_data[CNT_W-1:0];
            end else if (fire) begin
                r_count <= n_count;
            end
            if (fire) begin
                r_slot     <= n_slot;
                r_start    <= n_start;
                r_sync     <= n_sync;
                r_sync_err <= n_sync_err;
                r_chan_err <= n_chan_err;
                r_prev     <= n_prev;
                r_match    <= n_match;
                r_done     <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= MAX_SLOTS)
        else $error("slot counter beyond the slot limit");

    a_match_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match <= LOCK_FRAMES)
        else $error("match counter beyond the lock count");

    a_lock_after_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_match) == LOCK_FRAMES)
        else $error("count locked before enough matching frames");

    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("count lock dropped without reset");

    a_width_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.width_valid) |-> r_out.measured_width == '0)
        else $error("width reported on a beat without a falling edge");

endmodule
